>>> hw/rtl/filtered_pid_deadband_core_defines.svh
// ----------------------------------------------------------------------------
// filtered_pid_deadband_core_defines: assertion macros
// Shared concurrent assertion forms for the filtered PID core.
// ----------------------------------------------------------------------------
`ifndef FILTERED_PID_DEADBAND_CORE_DEFINES_SVH
`define FILTERED_PID_DEADBAND_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define FPD_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define FPD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/fpd_pkg.sv
// ----------------------------------------------------------------------------
// fpd_pkg: filtered PID core package
// Widths, register indexes and sequencer types of the filtered PID core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fpd_pkg;

  // Field and state widths
  localparam int SAMPLE_BITS    = 16;
  localparam int RAW_BITS       = SAMPLE_BITS + 1;
  localparam int ERR_BITS       = SAMPLE_BITS + 2;
  localparam int DIFF_BITS      = SAMPLE_BITS + 3;
  localparam int SUM_BITS       = 40;
  localparam int GAIN_BITS      = 16;
  localparam int WEIGHT_BITS    = 16;
  localparam int BAND_BITS      = 15;
  localparam int DRIVE_BITS     = 32;

  // Shared multiplier: operand magnitude split into two halves
  localparam int MAG_BITS       = SUM_BITS;
  localparam int HALF_BITS      = MAG_BITS / 2;
  localparam int MULB_BITS      = WEIGHT_BITS + 1;
  localparam int PROD_BITS      = HALF_BITS + MULB_BITS;
  localparam int ACC_BITS       = MAG_BITS + MULB_BITS;
  localparam int TOT_BITS       = ACC_BITS + 1;
  localparam int SRC_BITS       = SUM_BITS + 1;

  // Fixed point constants
  localparam int Q16_ONE        = 65536;
  localparam int Q16_SHIFT      = 16;
  localparam int OUT_SHIFT      = 8;
  localparam int DRIVE_SCALE    = 1000;
  localparam int ROUND_Q16      = 1 << (Q16_SHIFT - 1);
  localparam int ROUND_OUT      = 1 << (OUT_SHIFT - 1);

  // Configuration port
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 16;

  localparam logic [CFG_INDEX_BITS-1:0] REG_SET_POINT       = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_DEAD_BAND       = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_GAIN_P          = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_GAIN_I          = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_GAIN_D          = 3'd4;
  localparam logic [CFG_INDEX_BITS-1:0] REG_ERROR_SMOOTHING = 3'd5;
  localparam logic [CFG_INDEX_BITS-1:0] REG_DRIVE_SMOOTHING = 3'd6;

  // Sequencer steps
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_E_PREV,
    ST_E_RAW,
    ST_E_SAT,
    ST_E_UPD,
    ST_P,
    ST_I,
    ST_D,
    ST_PID_SUM,
    ST_F_PREV,
    ST_F_PID,
    ST_F_SUM,
    ST_SCALE,
    ST_FIN
  } state_t;

  // Phases of one multiply: low half, high half, accumulate
  typedef enum logic [1:0] {
    PH_LO,
    PH_HI,
    PH_ACC
  } phase_t;

  // Rounding and shift applied to a product
  typedef enum logic [1:0] {
    K_EXACT,
    K_Q16,
    K_OUT
  } kind_t;

endpackage

>>> hw/rtl/filtered_pid_deadband_core.sv
// ----------------------------------------------------------------------------
// filtered_pid_deadband_core: positional PID with dead band and smoothing
// Filters the error, applies a dead band, forms P, I and D terms, smooths
// their sum and scales it by 1000/256 with saturation to 32 bits.
// ----------------------------------------------------------------------------
// Usage:
//   cfg_*  : write channel, always ready; cfg_index selects the register
//            (set point, dead band, three gains, two smoothing weights),
//            cfg_data carries the value. Write only while the core is idle.
//   s_*    : one measurement per request (s_tdata, signed 16 bits).
//   m_*    : one result per measurement: m_tdata is the drive value,
//            m_tuser the clip flag.
//   Every product goes through one 20 x 17 bit multiplier, which takes one
//   pass per 20-bit half of the operand magnitude plus an accumulate step;
//   40-bit operands with a non-zero upper half take the extra pass.
//   A measurement is taken only once the last result has gone to the
//   output register; s_tready is high only while the sequencer is idle.
//   The result sits in an output register, so the next measurement is taken
//   while it waits. If the receiver still stalls when the next result is
//   done, the sequencer holds it until the output register is free.
//   Reset clears the sequencer, configuration, error history, integral and
//   smoothed controller value; no result is pending after reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "filtered_pid_deadband_core_defines.svh"

module filtered_pid_deadband_core (
  input  logic                                clk,
  input  logic                                rst,
  // configuration write channel
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [fpd_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [fpd_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  // measurement stream
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [fpd_pkg::SAMPLE_BITS-1:0]     s_tdata,   // [15:0] measurement
  // result stream
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [fpd_pkg::DRIVE_BITS-1:0]      m_tdata,   // [31:0] drive
  output logic [0:0]                          m_tuser    // [0] clipped
);

  import fpd_pkg::*;

  // Saturation limits at the width of the running total
  localparam logic signed [TOT_BITS-1:0] ERR_MAX_T =
    TOT_BITS'((64'sd1 <<< (ERR_BITS - 1)) - 64'sd1);
  localparam logic signed [TOT_BITS-1:0] ERR_MIN_T = -ERR_MAX_T - 1;
  localparam logic signed [TOT_BITS-1:0] SUM_MAX_T =
    TOT_BITS'((64'sd1 <<< (SUM_BITS - 1)) - 64'sd1);
  localparam logic signed [TOT_BITS-1:0] SUM_MIN_T = -SUM_MAX_T - 1;
  localparam logic signed [TOT_BITS-1:0] DRV_MAX_T =
    TOT_BITS'((64'sd1 <<< (DRIVE_BITS - 1)) - 64'sd1);
  localparam logic signed [TOT_BITS-1:0] DRV_MIN_T = -DRV_MAX_T - 1;

  // Magnitude of a signed gain
  function automatic logic [MULB_BITS-1:0] gain_mag(input logic signed [GAIN_BITS-1:0] g);
    logic signed [MULB_BITS-1:0] gx;
    gx = MULB_BITS'(g);
    return gx[MULB_BITS-1] ? MULB_BITS'(-gx) : MULB_BITS'(gx);
  endfunction

  // Configuration registers
  logic signed [GAIN_BITS-1:0]   set_point;
  logic        [BAND_BITS-1:0]   dead_band;
  logic signed [GAIN_BITS-1:0]   gain_p;
  logic signed [GAIN_BITS-1:0]   gain_i;
  logic signed [GAIN_BITS-1:0]   gain_d;
  logic        [WEIGHT_BITS-1:0] error_smoothing;
  logic        [WEIGHT_BITS-1:0] drive_smoothing;

  // Controller state
  logic signed [ERR_BITS-1:0]    last_error;
  logic signed [SUM_BITS-1:0]    error_sum;
  logic signed [SUM_BITS-1:0]    last_drive;

  // Sequencer
  state_t state, state_next;
  phase_t phase, phase_next;
  logic   clip_flag;

  // Working registers
  logic signed [RAW_BITS-1:0]    raw_err;
  logic signed [ERR_BITS-1:0]    cur_error;
  logic signed [DIFF_BITS-1:0]   diff_err;
  logic signed [SUM_BITS-1:0]    pid;
  logic        [ACC_BITS-1:0]    acc;
  logic signed [TOT_BITS-1:0]    total;

  // Operand decode
  logic signed [SRC_BITS-1:0]    op_src;
  logic        [MULB_BITS-1:0]   op_b;
  logic                          op_b_neg;
  kind_t                         op_kind;
  logic                          op_first;
  state_t                        op_after;
  logic                          is_mul;
  logic        [MAG_BITS-1:0]    op_a;
  logic                          op_neg;

  // Multiplier and accumulate path
  logic        [HALF_BITS-1:0]   mul_half;
  logic        [PROD_BITS-1:0]   prod;
  logic        [ACC_BITS-1:0]    round_add;
  logic        [ACC_BITS-1:0]    term;
  logic signed [TOT_BITS-1:0]    base;
  logic signed [TOT_BITS-1:0]    total_next;

  // Saturation and dead band
  logic signed [ERR_BITS-1:0]    e_sat;
  logic                          e_clip;
  logic        [ERR_BITS-1:0]    e_mag;
  logic signed [ERR_BITS-1:0]    e_gated;
  logic signed [SUM_BITS:0]      esum_wide;
  logic signed [SUM_BITS-1:0]    esum_sat;
  logic                          esum_clip;
  logic signed [SUM_BITS-1:0]    tot_sat40;
  logic                          tot_clip40;
  logic signed [DRIVE_BITS-1:0]  out_sat;
  logic                          out_clip;
  logic                          out_free;

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == ST_IDLE);
  assign out_free  = !m_tvalid || m_tready;

  // Decode the operands of the current step
  always_comb begin
    op_src   = '0;
    op_b     = '0;
    op_b_neg = 1'b0;
    op_kind  = K_EXACT;
    op_first = 1'b0;
    op_after = ST_IDLE;
    is_mul   = 1'b1;
    unique case (state)
      ST_E_PREV: begin
        op_src   = SRC_BITS'(last_error);
        op_b     = {1'b0, error_smoothing};
        op_kind  = K_Q16;
        op_first = 1'b1;
        op_after = ST_E_RAW;
      end
      ST_E_RAW: begin
        op_src   = SRC_BITS'(raw_err);
        op_b     = MULB_BITS'(Q16_ONE) - {1'b0, error_smoothing};
        op_kind  = K_Q16;
        op_after = ST_E_SAT;
      end
      ST_P: begin
        op_src   = SRC_BITS'(cur_error);
        op_b     = gain_mag(gain_p);
        op_b_neg = gain_p[GAIN_BITS-1];
        op_first = 1'b1;
        op_after = ST_I;
      end
      ST_I: begin
        op_src   = SRC_BITS'(error_sum);
        op_b     = gain_mag(gain_i);
        op_b_neg = gain_i[GAIN_BITS-1];
        op_after = ST_D;
      end
      ST_D: begin
        op_src   = SRC_BITS'(diff_err);
        op_b     = gain_mag(gain_d);
        op_b_neg = gain_d[GAIN_BITS-1];
        op_after = ST_PID_SUM;
      end
      ST_F_PREV: begin
        op_src   = SRC_BITS'(last_drive);
        op_b     = {1'b0, drive_smoothing};
        op_kind  = K_Q16;
        op_first = 1'b1;
        op_after = ST_F_PID;
      end
      ST_F_PID: begin
        op_src   = SRC_BITS'(pid);
        op_b     = MULB_BITS'(Q16_ONE) - {1'b0, drive_smoothing};
        op_kind  = K_Q16;
        op_after = ST_F_SUM;
      end
      ST_SCALE: begin
        op_src   = SRC_BITS'(last_drive);
        op_b     = MULB_BITS'(DRIVE_SCALE);
        op_kind  = K_OUT;
        op_first = 1'b1;
        op_after = ST_FIN;
      end
      default: begin
        is_mul   = 1'b0;
      end
    endcase
    op_neg = op_src[SRC_BITS-1] ^ op_b_neg;
    op_a   = op_src[SRC_BITS-1] ? MAG_BITS'(-op_src) : op_src[MAG_BITS-1:0];
  end

  // Multiply one half of the magnitude; round and shift the product as its kind asks, then add it
  always_comb begin
    mul_half = (phase == PH_LO) ? op_a[HALF_BITS-1:0] : op_a[MAG_BITS-1:HALF_BITS];
    prod     = {{(PROD_BITS-HALF_BITS){1'b0}}, mul_half} *
               {{(PROD_BITS-MULB_BITS){1'b0}}, op_b};
    case (op_kind)
      K_Q16: begin
        round_add = ACC_BITS'(ROUND_Q16);
        term      = acc >> Q16_SHIFT;
      end
      K_OUT: begin
        round_add = ACC_BITS'(ROUND_OUT);
        term      = acc >> OUT_SHIFT;
      end
      default: begin
        round_add = '0;
        term      = acc;
      end
    endcase
    base       = op_first ? '0 : total;
    total_next = op_neg ? base - $signed({1'b0, term}) : base + $signed({1'b0, term});
  end

  // Saturate, apply the dead band and clamp the stored values
  always_comb begin
    e_clip = 1'b0;
    if (total > ERR_MAX_T) begin
      e_sat  = ERR_BITS'(ERR_MAX_T);
      e_clip = 1'b1;
    end else if (total < ERR_MIN_T) begin
      e_sat  = ERR_BITS'(ERR_MIN_T);
      e_clip = 1'b1;
    end else begin
      e_sat  = total[ERR_BITS-1:0];
    end
    e_mag   = e_sat[ERR_BITS-1] ? ERR_BITS'(-e_sat) : ERR_BITS'(e_sat);
    e_gated = (e_mag < {{(ERR_BITS-BAND_BITS){1'b0}}, dead_band}) ? '0 : e_sat;

    esum_wide = (SUM_BITS+1)'(error_sum) + (SUM_BITS+1)'(cur_error);
    esum_clip = esum_wide[SUM_BITS] != esum_wide[SUM_BITS-1];
    if (esum_clip) begin
      esum_sat = esum_wide[SUM_BITS] ? SUM_BITS'(SUM_MIN_T) : SUM_BITS'(SUM_MAX_T);
    end else begin
      esum_sat = esum_wide[SUM_BITS-1:0];
    end

    tot_clip40 = 1'b0;
    if (total > SUM_MAX_T) begin
      tot_sat40  = SUM_BITS'(SUM_MAX_T);
      tot_clip40 = 1'b1;
    end else if (total < SUM_MIN_T) begin
      tot_sat40  = SUM_BITS'(SUM_MIN_T);
      tot_clip40 = 1'b1;
    end else begin
      tot_sat40  = total[SUM_BITS-1:0];
    end

    out_clip = 1'b0;
    if (total > DRV_MAX_T) begin
      out_sat  = DRIVE_BITS'(DRV_MAX_T);
      out_clip = 1'b1;
    end else if (total < DRV_MIN_T) begin
      out_sat  = DRIVE_BITS'(DRV_MIN_T);
      out_clip = 1'b1;
    end else begin
      out_sat  = total[DRIVE_BITS-1:0];
    end
  end

  // Next step of the sequencer
  always_comb begin
    state_next = state;
    phase_next = phase;
    unique case (state) inside
      ST_IDLE: begin
        if (s_tvalid) begin
          state_next = ST_E_PREV;
          phase_next = PH_LO;
        end
      end
      ST_E_PREV, ST_E_RAW, ST_P, ST_I, ST_D, ST_F_PREV, ST_F_PID, ST_SCALE: begin
        unique case (phase)
          PH_LO: begin
            phase_next = (op_a[MAG_BITS-1:HALF_BITS] != '0) ? PH_HI : PH_ACC;
          end
          PH_HI: begin
            phase_next = PH_ACC;
          end
          PH_ACC: begin
            phase_next = PH_LO;
            state_next = op_after;
          end
          default: begin
            phase_next = PH_LO;
          end
        endcase
      end
      ST_E_SAT:   state_next = ST_E_UPD;
      ST_E_UPD:   state_next = ST_P;
      ST_PID_SUM: state_next = ST_F_PREV;
      ST_F_SUM:   state_next = ST_SCALE;
      ST_FIN: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
        phase_next = PH_LO;
      end
    endcase
  end

  // Hold the sequencer, configuration and controller state
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      phase           <= PH_LO;
      m_tvalid        <= 1'b0;
      clip_flag       <= 1'b0;
      set_point       <= '0;
      dead_band       <= '0;
      gain_p          <= '0;
      gain_i          <= '0;
      gain_d          <= '0;
      error_smoothing <= '0;
      drive_smoothing <= '0;
      last_error      <= '0;
      error_sum       <= '0;
      last_drive      <= '0;
    end else begin
      state <= state_next;
      phase <= phase_next;

      // write a configuration register; drop indexes beyond the list
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_SET_POINT:       set_point       <= GAIN_BITS'(cfg_data);
          REG_DEAD_BAND:       dead_band       <= cfg_data[BAND_BITS-1:0];
          REG_GAIN_P:          gain_p          <= GAIN_BITS'(cfg_data);
          REG_GAIN_I:          gain_i          <= GAIN_BITS'(cfg_data);
          REG_GAIN_D:          gain_d          <= GAIN_BITS'(cfg_data);
          REG_ERROR_SMOOTHING: error_smoothing <= cfg_data[WEIGHT_BITS-1:0];
          REG_DRIVE_SMOOTHING: drive_smoothing <= cfg_data[WEIGHT_BITS-1:0];
          default: ;
        endcase
      end

      // retire a taken result; the finishing step refills the register itself
      if (m_tvalid && m_tready && state != ST_FIN) begin
        m_tvalid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            clip_flag <= 1'b0;
          end
        end
        ST_E_SAT: begin
          clip_flag <= clip_flag | e_clip;
        end
        ST_E_UPD: begin
          error_sum  <= esum_sat;
          last_error <= cur_error;
          clip_flag  <= clip_flag | esum_clip;
        end
        ST_PID_SUM: begin
          clip_flag <= clip_flag | tot_clip40;
        end
        ST_F_SUM: begin
          last_drive <= tot_sat40;
          clip_flag  <= clip_flag | tot_clip40;
        end
        ST_FIN: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // Advance the datapath registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          raw_err <= RAW_BITS'(signed'(s_tdata)) - RAW_BITS'(set_point);
        end
      end
      ST_E_SAT: begin
        cur_error <= e_gated;
      end
      ST_E_UPD: begin
        diff_err <= DIFF_BITS'(cur_error) - DIFF_BITS'(last_error);
      end
      ST_PID_SUM: begin
        pid <= tot_sat40;
      end
      ST_FIN: begin
        if (out_free) begin
          m_tdata    <= out_sat;
          m_tuser[0] <= clip_flag | out_clip;
        end
      end
      default: begin
        if (is_mul) begin
          case (phase)
            PH_LO:   acc   <= {{(ACC_BITS-PROD_BITS){1'b0}}, prod} + round_add;
            PH_HI:   acc   <= acc + {prod, {HALF_BITS{1'b0}}};
            PH_ACC:  total <= total_next;
            default: ;
          endcase
        end
      end
    endcase
  end

  // Assertions
  `FPD_ASSERT_NEXT(a_start_step, clk, rst, s_tvalid && s_tready,
    state == ST_E_PREV && phase == PH_LO, "request accepted but sequencer did not start")
  `FPD_ASSERT_IMPLY(a_hi_after_lo, clk, rst, phase == PH_HI,
    $past(phase) == PH_LO, "high half pass not preceded by low half pass")
  `FPD_ASSERT_IMPLY(a_phase_rest, clk, rst, !is_mul,
    phase == PH_LO, "multiply phase left active outside a multiply step")
  `FPD_ASSERT_NEXT(a_fin_hold, clk, rst, state == ST_FIN && m_tvalid && !m_tready,
    state == ST_FIN, "finished result overwrote a stalled output")

endmodule
